>>> src/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types and constants for the contour blob tracker.
// ----------------------------------------------------------------------------
package cbt_pkg;

  // default coordinate width in bits
  localparam int unsigned CoordBitsDef = 12;

  // frame dimension registers
  localparam int unsigned DimBits = 13;
  localparam logic [DimBits-1:0] FrameWidthRst  = 13'd640;
  localparam logic [DimBits-1:0] FrameHeightRst = 13'd480;

  // configuration register index
  localparam int unsigned CfgIdxBits = 8;
  localparam logic [CfgIdxBits-1:0] CfgFrameWidth  = 8'd0;
  localparam logic [CfgIdxBits-1:0] CfgFrameHeight = 8'd1;

  // what a point word means
  typedef enum logic [1:0] {
    CMD_POINT       = 2'd0,
    CMD_END_CONTOUR = 2'd1,
    CMD_END_FRAME   = 2'd2,
    CMD_FRAME_ONLY  = 2'd3
  } cmd_e;

endpackage

>>> src/contour_blob_tracker_top.sv
// ----------------------------------------------------------------------------
// contour_blob_tracker_top
// Bounding box per contour, nearest contour to the tracked blob per frame.
// A frame-end word shows its result after passing the input register, the
// score register and then the output register.
// Throughput: one word per cycle; words stall only behind a frame result
// that meets a full, untaken output register.
// Reset: tracked blob at the frame middle, frame 640 x 480, pipeline empty.
// ----------------------------------------------------------------------------
module contour_blob_tracker_top #(
  parameter int unsigned COORD_BITS = cbt_pkg::CoordBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  // configuration write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cbt_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [cbt_pkg::DimBits-1:0]     cfg_data_i,

  // point words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // point_x, point_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // cmd
  input  logic [1:0]                      s_axis_tuser,

  // frame results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // center_x, center_y, radius, zero padding
  output logic [((3*COORD_BITS+6)/8)*8-1:0] m_axis_tdata,
  // found
  output logic                            m_axis_tuser
);
  import cbt_pkg::*;

  localparam int unsigned CB      = COORD_BITS;
  localparam int unsigned RB      = COORD_BITS - 1;
  localparam int unsigned SB      = COORD_BITS + 2;
  localparam int unsigned OutW    = ((3*COORD_BITS+6)/8)*8;
  localparam int unsigned OutPad  = OutW - (3*COORD_BITS-1);
  localparam logic [31:0] CoordMax = (32'd1 << COORD_BITS) - 32'd1;
  localparam logic [DimBits-1:0] RstDimMax =
      (FrameWidthRst > FrameHeightRst) ? FrameWidthRst : FrameHeightRst;

  // ---------------------------------------------------------------- config
  logic [DimBits-1:0] frame_width_q, frame_height_q;
  logic [CB-1:0]      tracked_x_q, tracked_y_q, tracked_radius_q;
  logic [CB-1:0]      tracked_x_d, tracked_y_d, tracked_radius_d;
  logic               cfg_fire;
  logic [DimBits-1:0] cfg_w, cfg_h, cfg_max;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_w   = (cfg_index_i == CfgFrameWidth)  ? cfg_data_i : frame_width_q;
    cfg_h   = (cfg_index_i == CfgFrameHeight) ? cfg_data_i : frame_height_q;
    cfg_max = (cfg_w > cfg_h) ? cfg_w : cfg_h;
  end

  // ---------------------------------------------------------- input stage
  logic               p0_valid_q;
  cmd_e               p0_cmd_q;
  logic [CB-1:0]      p0_x_q, p0_y_q;
  logic               p0_ready, a_go;

  // --------------------------------------------------------- box stage
  logic               box_empty_q;
  logic [CB-1:0]      box_min_x_q, box_max_x_q, box_min_y_q, box_max_y_q;
  logic [CB-1:0]      nb_min_x, nb_max_x, nb_min_y, nb_max_y;
  logic               p0_has_point;

  logic               p1_valid_q, p1_end_q, p1_frame_q;
  logic [CB-1:0]      p1_min_x_q, p1_max_x_q, p1_min_y_q, p1_max_y_q;
  logic               p1_ready, b_go, out_free;

  assign p0_has_point = (p0_cmd_q != CMD_FRAME_ONLY);

  always_comb begin
    if (box_empty_q) begin
      nb_min_x = p0_x_q;
      nb_max_x = p0_x_q;
      nb_min_y = p0_y_q;
      nb_max_y = p0_y_q;
    end else begin
      nb_min_x = (p0_x_q < box_min_x_q) ? p0_x_q : box_min_x_q;
      nb_max_x = (p0_x_q > box_max_x_q) ? p0_x_q : box_max_x_q;
      nb_min_y = (p0_y_q < box_min_y_q) ? p0_y_q : box_min_y_q;
      nb_max_y = (p0_y_q > box_max_y_q) ? p0_y_q : box_max_y_q;
    end
  end

  // --------------------------------------------------------- score stage
  logic [CB-1:0] ex, ey, ext, cx, cy;
  logic [RB-1:0] r;
  logic [CB-1:0] dx, dy, dr;
  logic [SB-1:0] score;
  logic          take;
  logic          win_have;
  logic [CB-1:0] win_x, win_y;
  logic [RB-1:0] win_r;

  logic [SB-1:0] best_score_q;
  logic [CB-1:0] best_x_q, best_y_q;
  logic [RB-1:0] best_radius_q;
  logic          have_best_q;

  always_comb begin
    ex    = p1_max_x_q - p1_min_x_q;
    ey    = p1_max_y_q - p1_min_y_q;
    ext   = (ex > ey) ? ex : ey;
    cx    = p1_max_x_q - {1'b0, ex[CB-1:1]};
    cy    = p1_max_y_q - {1'b0, ey[CB-1:1]};
    r     = ext[CB-1:1];
    dx    = (tracked_x_q > cx) ? (tracked_x_q - cx) : (cx - tracked_x_q);
    dy    = (tracked_y_q > cy) ? (tracked_y_q - cy) : (cy - tracked_y_q);
    dr    = (tracked_radius_q > {1'b0, r}) ? (tracked_radius_q - {1'b0, r})
                                           : ({1'b0, r} - tracked_radius_q);
    score = {2'b00, dx} + {2'b00, dy} + {2'b00, dr};
    // earlier contour wins a tie
    take  = p1_end_q && (!have_best_q || (score < best_score_q));
    win_have = have_best_q || p1_end_q;
    if (take) begin
      win_x = cx;
      win_y = cy;
      win_r = r;
    end else if (have_best_q) begin
      win_x = best_x_q;
      win_y = best_y_q;
      win_r = best_radius_q;
    end else begin
      win_x = '0;
      win_y = '0;
      win_r = '0;
    end
  end

  // ------------------------------------------------------------ handshake
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign b_go          = p1_valid_q && (!p1_frame_q || out_free);
  assign p1_ready      = !p1_valid_q || b_go;
  assign a_go          = p0_valid_q && p1_ready;
  assign p0_ready      = !p0_valid_q || a_go;
  assign s_axis_tready = p0_ready;

  // tracked blob: config reload, or the frame winner
  always_comb begin
    tracked_x_d      = tracked_x_q;
    tracked_y_d      = tracked_y_q;
    tracked_radius_d = tracked_radius_q;
    if (cfg_fire &&
        (cfg_index_i == CfgFrameWidth || cfg_index_i == CfgFrameHeight)) begin
      if (cfg_index_i == CfgFrameWidth) begin
        tracked_x_d = CB'(cfg_data_i >> 1);
      end else begin
        tracked_y_d = CB'(cfg_data_i >> 1);
      end
      tracked_radius_d = (32'(cfg_max) > CoordMax) ? '1 : CB'(cfg_max);
    end else if (b_go && p1_frame_q) begin
      tracked_x_d      = win_x;
      tracked_y_d      = win_y;
      tracked_radius_d = (win_r == '0) ? CB'(1) : {1'b0, win_r};
    end
  end

  // -------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= FrameWidthRst;
      frame_height_q   <= FrameHeightRst;
      tracked_x_q      <= CB'(FrameWidthRst >> 1);
      tracked_y_q      <= CB'(FrameHeightRst >> 1);
      tracked_radius_q <= (32'(RstDimMax) > CoordMax) ? '1 : CB'(RstDimMax);
      p0_valid_q       <= 1'b0;
      box_empty_q      <= 1'b1;
      p1_valid_q       <= 1'b0;
      have_best_q      <= 1'b0;
      best_score_q     <= '0;
      best_x_q         <= '0;
      best_y_q         <= '0;
      best_radius_q    <= '0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      tracked_x_q      <= tracked_x_d;
      tracked_y_q      <= tracked_y_d;
      tracked_radius_q <= tracked_radius_d;
      if (cfg_fire && cfg_index_i == CfgFrameWidth) begin
        frame_width_q <= cfg_data_i;
      end
      if (cfg_fire && cfg_index_i == CfgFrameHeight) begin
        frame_height_q <= cfg_data_i;
      end

      if (s_axis_tvalid && s_axis_tready) begin
        p0_valid_q <= 1'b1;
      end else if (a_go) begin
        p0_valid_q <= 1'b0;
      end

      if (a_go) begin
        // any word but a plain point closes the box
        box_empty_q <= (p0_cmd_q != CMD_POINT);
        p1_valid_q  <= (p0_cmd_q != CMD_POINT);
      end else if (b_go) begin
        p1_valid_q  <= 1'b0;
      end

      if (b_go) begin
        if (p1_frame_q) begin
          have_best_q   <= 1'b0;
          best_score_q  <= '0;
          best_x_q      <= '0;
          best_y_q      <= '0;
          best_radius_q <= '0;
        end else if (take) begin
          have_best_q   <= 1'b1;
          best_score_q  <= score;
          best_x_q      <= cx;
          best_y_q      <= cy;
          best_radius_q <= r;
        end
      end

      if (b_go && p1_frame_q) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      p0_cmd_q <= cmd_e'(s_axis_tuser);
      p0_x_q   <= s_axis_tdata[CB-1:0];
      p0_y_q   <= s_axis_tdata[2*CB-1:CB];
    end
    if (a_go && p0_has_point) begin
      box_min_x_q <= nb_min_x;
      box_max_x_q <= nb_max_x;
      box_min_y_q <= nb_min_y;
      box_max_y_q <= nb_max_y;
    end
    if (a_go) begin
      p1_end_q   <= (p0_cmd_q == CMD_END_CONTOUR) || (p0_cmd_q == CMD_END_FRAME);
      p1_frame_q <= (p0_cmd_q == CMD_END_FRAME) || (p0_cmd_q == CMD_FRAME_ONLY);
      p1_min_x_q <= nb_min_x;
      p1_max_x_q <= nb_max_x;
      p1_min_y_q <= nb_min_y;
      p1_max_y_q <= nb_max_y;
    end
    if (b_go && p1_frame_q) begin
      m_axis_tdata <= {{OutPad{1'b0}}, win_r, win_y, win_x};
      m_axis_tuser <= win_have;
    end
  end

  // ----------------------------------------------------------- assertions
  // an empty frame reports an all-zero blob
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("empty frame result carries a nonzero blob");

  // the score stage only ever holds a contour end or a frame end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid_q && !p1_frame_q |-> p1_end_q)
    else $error("score stage holds a word with no work");

  // a plain point always leaves an open box behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_go && p0_cmd_q == CMD_POINT |=> !box_empty_q)
    else $error("box empty after a plain point");

  // a contour end always leaves a candidate in the best registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_go && p1_end_q && !p1_frame_q |=> have_best_q)
    else $error("contour end left no best candidate");

endmodule
